### design/bounded_cycle_counter_defines.svh
// Assertion macros used by the checker file of the cycle counter
`ifndef BOUNDED_CYCLE_COUNTER_DEFINES_SVH
`define BOUNDED_CYCLE_COUNTER_DEFINES_SVH

// consequent in the same cycle
`define BCC_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent in the following cycle
`define BCC_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/bcc_pkg.sv
// Types and constants shared by the cycle counter modules
package bcc_pkg;

  localparam int NODE_W = 16;
  localparam int CNT_W  = 32;
  localparam int ST_W   = 2;
  localparam int LVLS   = 6;
  localparam int LVL_W  = 3;
  localparam int NCNT   = 5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] MARK_ONE_BACK   = 3'd7;
  localparam logic [2:0] MARK_TWO_BACK   = 3'd6;
  localparam logic [2:0] MARK_THREE_BACK = 3'd4;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_EDGE_WR,
    S_BM_SELF_RD, S_BM_SELF_WR, S_BM_ENTER, S_BM_DEG, S_BM_NEXT,
    S_BM_CAND, S_BM_EVAL, S_BM_MARK_WR, S_BM_STEP,
    S_W_ENTER, S_W_DEG, S_W_NEXT, S_W_CAND, S_W_MARK, S_W_EVAL,
    S_CLR_START, S_CLR_ALL, S_CLR_LIST, S_CLR_LIST_WR, S_CLR_FIN, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_INIT_CLR, CMD_LOAD, CMD_SET_BAD, CMD_EDGE_RD, CMD_EDGE_WR,
    CMD_BM_START, CMD_DEG_SET, CMD_CAND, CMD_MARK_WR, CMD_PUSH, CMD_ADV,
    CMD_POP, CMD_COUNT, CMD_CLR_BEGIN, CMD_MARK_SWEEP, CMD_LIST_RD,
    CMD_LIST_CLR, CMD_CLR_FIN, CMD_PUBLISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    walk;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_count;
    logic bad_node;
    logic sweep_last;
    logic lvl_done;
    logic lvl_top;
    logic lvl_last_bm;
    logic bm_skip;
    logic wk_skip;
    logic wk_count;
    logic overflow;
    logic list_end;
  } sts_t;

endpackage

### design/bcc_ctrl.sv
// Sequencer for edge insertion, back marking, forward walk and mark clearing
module bcc_ctrl
  import bcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    cmd.walk   = 1'b0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.op = CMD_INIT_CLR;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.bad_node) begin
          cmd.op     = CMD_SET_BAD;
          state_next = S_DONE;
        end else if (sts.is_count) begin
          cmd.op     = CMD_BM_START;
          state_next = S_BM_SELF_RD;
        end else begin
          cmd.op     = CMD_EDGE_RD;
          state_next = S_EDGE_WR;
        end
      end
      S_EDGE_WR: begin
        cmd.op     = CMD_EDGE_WR;
        state_next = S_DONE;
      end
      S_BM_SELF_RD: state_next = S_BM_SELF_WR;
      S_BM_SELF_WR: begin
        cmd.op     = CMD_MARK_WR;
        state_next = S_BM_ENTER;
      end
      S_BM_ENTER: state_next = S_BM_DEG;
      S_BM_DEG: begin
        cmd.op     = CMD_DEG_SET;
        state_next = S_BM_NEXT;
      end
      S_BM_NEXT: begin
        if (!sts.lvl_done) begin
          state_next = S_BM_CAND;
        end else if (sts.lvl_top) begin
          state_next = S_W_ENTER;
        end else begin
          cmd.op = CMD_POP;
        end
      end
      S_BM_CAND: begin
        cmd.op     = CMD_CAND;
        state_next = S_BM_EVAL;
      end
      S_BM_EVAL: begin
        if (sts.bm_skip) begin
          cmd.op     = CMD_ADV;
          state_next = S_BM_NEXT;
        end else begin
          state_next = S_BM_MARK_WR;
        end
      end
      S_BM_MARK_WR: begin
        cmd.op     = CMD_MARK_WR;
        state_next = S_BM_STEP;
      end
      S_BM_STEP: begin
        if (sts.lvl_last_bm) begin
          cmd.op     = CMD_ADV;
          state_next = S_BM_NEXT;
        end else begin
          cmd.op     = CMD_PUSH;
          state_next = S_BM_ENTER;
        end
      end
      S_W_ENTER: begin
        cmd.walk   = 1'b1;
        state_next = S_W_DEG;
      end
      S_W_DEG: begin
        cmd.op     = CMD_DEG_SET;
        cmd.walk   = 1'b1;
        state_next = S_W_NEXT;
      end
      S_W_NEXT: begin
        cmd.walk = 1'b1;
        if (!sts.lvl_done) begin
          state_next = S_W_CAND;
        end else if (sts.lvl_top) begin
          cmd.op     = CMD_CLR_BEGIN;
          state_next = S_CLR_START;
        end else begin
          cmd.op = CMD_POP;
        end
      end
      S_W_CAND: begin
        cmd.op     = CMD_CAND;
        cmd.walk   = 1'b1;
        state_next = S_W_MARK;
      end
      S_W_MARK: begin
        cmd.walk   = 1'b1;
        state_next = S_W_EVAL;
      end
      S_W_EVAL: begin
        cmd.walk = 1'b1;
        if (sts.wk_skip) begin
          cmd.op     = CMD_ADV;
          state_next = S_W_NEXT;
        end else if (sts.wk_count) begin
          cmd.op     = CMD_COUNT;
          state_next = S_W_NEXT;
        end else begin
          cmd.op     = CMD_PUSH;
          state_next = S_W_ENTER;
        end
      end
      S_CLR_START: begin
        state_next = sts.overflow ? S_CLR_ALL : S_CLR_LIST;
      end
      S_CLR_ALL: begin
        cmd.op = CMD_MARK_SWEEP;
        if (sts.sweep_last) state_next = S_CLR_FIN;
      end
      S_CLR_LIST: begin
        if (sts.list_end) begin
          state_next = S_CLR_FIN;
        end else begin
          cmd.op     = CMD_LIST_RD;
          state_next = S_CLR_LIST_WR;
        end
      end
      S_CLR_LIST_WR: begin
        cmd.op     = CMD_LIST_CLR;
        state_next = S_CLR_LIST;
      end
      S_CLR_FIN: begin
        cmd.op     = CMD_CLR_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op     = CMD_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

### design/bcc_datapath.sv
// Graph tables, mark store, walk stack, counters and result register
module bcc_datapath
  import bcc_pkg::*;
#(
  parameter int NODES           = 65536,
  parameter int MAX_DEGREE      = 32,
  parameter int MARK_LIST_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              operation,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic [NODE_W-1:0] start_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [CNT_W-1:0]  cycles_len3,
  output logic [CNT_W-1:0]  cycles_len4,
  output logic [CNT_W-1:0]  cycles_len5,
  output logic [CNT_W-1:0]  cycles_len6,
  output logic [CNT_W-1:0]  cycles_len7,
  output logic [CNT_W-1:0]  cycles_total
);

  localparam int NIW = $clog2(NODES);
  localparam int TAW = $clog2(NODES * MAX_DEGREE);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int MLW = $clog2(MARK_LIST_DEPTH);
  localparam int MCW = $clog2(MARK_LIST_DEPTH + 1);

  function automatic logic [NIW-1:0] nidx(input logic [NODE_W-1:0] n);
    return NIW'(n);
  endfunction

  function automatic logic [TAW-1:0] taddr(input logic [NODE_W-1:0] n,
                                           input logic [DW-1:0] k);
    return TAW'(nidx(n)) * TAW'(MAX_DEGREE) + TAW'(k);
  endfunction

  function automatic logic in_range(input logic [NODE_W-1:0] n);
    return {16'd0, n} < 32'(NODES);
  endfunction

  logic [NODE_W-1:0] succ_mem [NODES*MAX_DEGREE];
  logic [NODE_W-1:0] pred_mem [NODES*MAX_DEGREE];
  logic [DW-1:0]     scnt_mem [NODES];
  logic [DW-1:0]     pcnt_mem [NODES];
  logic [2:0]        mark_mem [NODES];
  logic [NODE_W-1:0] mlist_mem [MARK_LIST_DEPTH];

  logic [NODE_W-1:0] succ_q, pred_q, mlist_q;
  logic [DW-1:0]     scnt_q, pcnt_q;
  logic [2:0]        mark_q;

  logic              op_q;
  logic [NODE_W-1:0] u_q, v_q, s_q, cand;
  logic [NODE_W-1:0] path [LVLS];
  logic [DW-1:0]     idx [LVLS];
  logic [DW-1:0]     deg [LVLS];
  logic [LVL_W-1:0]  lvl;
  logic [MCW-1:0]    mcount, clr_idx;
  logic              ovf;
  logic [NIW-1:0]    sweep;
  logic [CNT_W-1:0]  cnt [NCNT];
  logic [CNT_W-1:0]  total;
  logic [ST_W-1:0]   st;

  logic [NODE_W-1:0] cur;
  logic [TAW-1:0]    tab_ra;
  logic              full, eq, lt, inpath, nomark, wk_skip, wk_count;
  logic [LVL_W-1:0]  cidx;
  logic [2:0]        mbits;
  logic              scnt_we, pcnt_we, tab_we, mark_we;
  logic [NIW-1:0]    scnt_wa, pcnt_wa, mark_wa;
  logic [DW-1:0]     scnt_wd, pcnt_wd;
  logic [2:0]        mark_wd;

  always_comb begin
    cur    = path[lvl];
    tab_ra = taddr(cur, idx[lvl]);
    full   = (scnt_q >= DW'(MAX_DEGREE)) || (pcnt_q >= DW'(MAX_DEGREE));
    eq     = cand == s_q;
    lt     = cand < s_q;
    inpath = 1'b0;
    for (int k = 1; k < LVLS; k++) begin
      if ((LVL_W'(k) <= lvl) && (path[k] == cand)) inpath = 1'b1;
    end
    case (lvl)
      3'd3:    nomark = !mark_q[2];
      3'd4:    nomark = !mark_q[1];
      3'd5:    nomark = !mark_q[0];
      default: nomark = 1'b0;
    endcase
    case (lvl)
      3'd0:    mbits = MARK_ONE_BACK;
      3'd1:    mbits = MARK_TWO_BACK;
      default: mbits = MARK_THREE_BACK;
    endcase
    wk_skip  = lt || nomark || (eq && (lvl < 3'd2)) || (!eq && inpath);
    wk_count = eq || (lvl == 3'd5);
    cidx     = eq ? (lvl - 3'd2) : 3'd4;

    sts.out_free    = !out_valid || out_ready;
    sts.is_count    = op_q;
    sts.bad_node    = op_q ? !in_range(s_q) : (!in_range(u_q) || !in_range(v_q));
    sts.sweep_last  = sweep == NIW'(NODES - 1);
    sts.lvl_done    = idx[lvl] == deg[lvl];
    sts.lvl_top     = lvl == '0;
    sts.lvl_last_bm = lvl == 3'd2;
    sts.bm_skip     = (cand <= s_q) || ((lvl == 3'd2) && (cand == path[1]));
    sts.wk_skip     = wk_skip;
    sts.wk_count    = wk_count;
    sts.overflow    = ovf;
    sts.list_end    = clr_idx == mcount;

    scnt_we = (cmd.op == CMD_INIT_CLR) || ((cmd.op == CMD_EDGE_WR) && !full);
    pcnt_we = scnt_we;
    tab_we  = (cmd.op == CMD_EDGE_WR) && !full;
    scnt_wa = (cmd.op == CMD_INIT_CLR) ? sweep : nidx(u_q);
    pcnt_wa = (cmd.op == CMD_INIT_CLR) ? sweep : nidx(v_q);
    scnt_wd = (cmd.op == CMD_INIT_CLR) ? '0 : scnt_q + DW'(1);
    pcnt_wd = (cmd.op == CMD_INIT_CLR) ? '0 : pcnt_q + DW'(1);

    mark_we = 1'b0;
    mark_wa = sweep;
    mark_wd = '0;
    case (cmd.op)
      CMD_INIT_CLR, CMD_MARK_SWEEP: mark_we = 1'b1;
      CMD_MARK_WR: begin
        mark_we = 1'b1;
        mark_wa = nidx(cand);
        mark_wd = mark_q | mbits;
      end
      CMD_LIST_CLR: begin
        mark_we = 1'b1;
        mark_wa = nidx(mlist_q);
      end
      default: mark_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      succ_mem[taddr(u_q, scnt_q)] <= v_q;
      pred_mem[taddr(v_q, pcnt_q)] <= u_q;
    end
    succ_q <= succ_mem[tab_ra];
    pred_q <= pred_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (scnt_we) scnt_mem[scnt_wa] <= scnt_wd;
    if (pcnt_we) pcnt_mem[pcnt_wa] <= pcnt_wd;
    scnt_q <= scnt_mem[(cmd.op == CMD_EDGE_RD) ? nidx(u_q) : nidx(cur)];
    pcnt_q <= pcnt_mem[(cmd.op == CMD_EDGE_RD) ? nidx(v_q) : nidx(cur)];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_q <= mark_mem[nidx(cand)];
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == CMD_MARK_WR) && (mcount < MCW'(MARK_LIST_DEPTH))) begin
      mlist_mem[mcount[MLW-1:0]] <= cand;
    end
    mlist_q <= mlist_mem[clr_idx[MLW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      mcount    <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      lvl       <= '0;
    end else begin
      if (cmd.op == CMD_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        CMD_INIT_CLR, CMD_MARK_SWEEP: sweep <= sweep + NIW'(1);
        CMD_LOAD: begin
          op_q  <= operation;
          u_q   <= from_node;
          v_q   <= to_node;
          s_q   <= start_node;
          st    <= ST_OK;
          total <= '0;
          for (int k = 0; k < NCNT; k++) cnt[k] <= '0;
        end
        CMD_SET_BAD: st <= ST_RANGE;
        CMD_EDGE_WR: if (full) st <= ST_FULL;
        CMD_BM_START: begin
          lvl     <= '0;
          path[0] <= s_q;
          cand    <= s_q;
        end
        CMD_DEG_SET: begin
          deg[lvl] <= cmd.walk ? scnt_q : pcnt_q;
          idx[lvl] <= '0;
        end
        CMD_CAND: cand <= cmd.walk ? succ_q : pred_q;
        CMD_MARK_WR: begin
          if (mcount < MCW'(MARK_LIST_DEPTH)) begin
            mcount <= mcount + MCW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        CMD_PUSH: begin
          for (int k = 1; k < LVLS; k++) begin
            if (LVL_W'(k) == lvl + 3'd1) path[k] <= cand;
          end
          lvl <= lvl + 3'd1;
        end
        CMD_ADV: idx[lvl] <= idx[lvl] + DW'(1);
        CMD_POP: begin
          lvl                <= lvl - 3'd1;
          idx[lvl - 3'd1]    <= idx[lvl - 3'd1] + DW'(1);
        end
        CMD_COUNT: begin
          idx[lvl] <= idx[lvl] + DW'(1);
          for (int k = 0; k < NCNT; k++) begin
            if ((cidx == LVL_W'(k)) && (cnt[k] != '1)) cnt[k] <= cnt[k] + CNT_W'(1);
          end
          if (total != '1) total <= total + CNT_W'(1);
        end
        CMD_CLR_BEGIN: begin
          sweep   <= '0;
          clr_idx <= '0;
        end
        CMD_LIST_RD: clr_idx <= clr_idx + MCW'(1);
        CMD_CLR_FIN: begin
          mcount <= '0;
          ovf    <= 1'b0;
        end
        CMD_PUBLISH: begin
          status       <= st;
          cycles_len3  <= cnt[0];
          cycles_len4  <= cnt[1];
          cycles_len5  <= cnt[2];
          cycles_len6  <= cnt[3];
          cycles_len7  <= cnt[4];
          cycles_total <= total;
        end
        default: lvl <= lvl;
      endcase
    end
  end

endmodule

### design/bounded_cycle_counter.sv
// Bounded-length directed cycle counter, top level
// Keeps a directed graph of up to NODES nodes with at most MAX_DEGREE successors
// and predecessors per node. One item is worked at a time; a finished result sits
// in an output register while the next item is taken, and a further result is
// held back until that register has been read. After reset a clearing pass over
// all NODES entries runs before the first item. A count marks nodes up to three
// steps back along predecessor entries, then walks forward along successor entries
// over paths of up to seven nodes, and then clears the marks, by the list of marked
// nodes or, if more than MARK_LIST_DEPTH marks were made, by a sweep over all NODES
// entries. Each adjacency table has a single read port, so the time a count takes
// depends on the graph.
module bounded_cycle_counter
  import bcc_pkg::*;
#(
  parameter int NODES           = 65536,
  parameter int MAX_DEGREE      = 32,
  parameter int MARK_LIST_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic [NODE_W-1:0] start_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [CNT_W-1:0]  cycles_len3,
  output logic [CNT_W-1:0]  cycles_len4,
  output logic [CNT_W-1:0]  cycles_len5,
  output logic [CNT_W-1:0]  cycles_len6,
  output logic [CNT_W-1:0]  cycles_len7,
  output logic [CNT_W-1:0]  cycles_total
);

  cmd_t cmd;
  sts_t sts;

  bcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bcc_datapath #(
    .NODES           (NODES),
    .MAX_DEGREE      (MAX_DEGREE),
    .MARK_LIST_DEPTH (MARK_LIST_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .from_node    (from_node),
    .to_node      (to_node),
    .start_node   (start_node),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cycles_len3  (cycles_len3),
    .cycles_len4  (cycles_len4),
    .cycles_len5  (cycles_len5),
    .cycles_len6  (cycles_len6),
    .cycles_len7  (cycles_len7),
    .cycles_total (cycles_total)
  );

endmodule

### design/bcc_checker.sv
// Port-level checks for the cycle counter and their binding
`include "bounded_cycle_counter_defines.svh"

module bcc_checker
  import bcc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ST_W-1:0]   status,
  input logic [CNT_W-1:0]  cycles_len3,
  input logic [CNT_W-1:0]  cycles_len7,
  input logic [CNT_W-1:0]  cycles_total
);

  `BCC_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(cycles_total))
  `BCC_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `BCC_SAME(a_err_no_counts, clk, rst, out_valid && (status != ST_OK), cycles_total == '0)
  `BCC_SAME(a_total_bound, clk, rst, out_valid, (cycles_total >= cycles_len3) && (cycles_total >= cycles_len7))

endmodule

bind bounded_cycle_counter bcc_checker u_bcc_checker (.*);
